@@ src/rfc_pkg.sv @@
// rfc_pkg: shared constants, types and lookup functions for the reciprocal
// frequency counter. No dependencies; used by the top level and its checker.

package rfc_pkg;

  localparam int COUNT_BITS   = 32;  // width of the free-running counts
  localparam int IN_CNT_W     = 32;  // count field width on the input word
  localparam int REF_W        = 27;  // reference frequency register width
  localparam int FREQ_W       = 40;  // frequency field width in mHz
  localparam int OFF_W        = 16;  // correction offset width
  localparam int SCALED_W     = 31;  // 10*ref + offset when positive
  localparam int IN_TDATA_W   = 72;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_TDATA_W  = 88;
  localparam int OUT_TUSER_W  = 1;

  localparam logic [REF_W-1:0]  REF_RESET   = REF_W'(10000000);
  localparam logic [FREQ_W-1:0] KHZ_LIMIT   = FREQ_W'(990000);
  localparam logic [FREQ_W-1:0] MHZ_LIMIT   = FREQ_W'(990000000);
  localparam int                OFF_MAX     = 32767;
  localparam int                OFF_MIN     = -32768;

  // action codes
  localparam logic ACT_GATE  = 1'b0;
  localparam logic ACT_RANGE = 1'b1;

  // range codes
  localparam logic [1:0] RANGE_QUARTER = 2'd0;
  localparam logic [1:0] RANGE_ONE     = 2'd1;
  localparam logic [1:0] RANGE_TEN     = 2'd2;

  // unit codes
  localparam logic [1:0] UNIT_HZ  = 2'd0;
  localparam logic [1:0] UNIT_KHZ = 2'd1;
  localparam logic [1:0] UNIT_MHZ = 2'd2;

  localparam logic [1:0] CAL_EDGES = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_FIN  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  function automatic logic [13:0] gate_ms(input logic [1:0] rng);
    logic [13:0] ms;
    case (rng)
      RANGE_ONE: ms = 14'd980;
      RANGE_TEN: ms = 14'd9980;
      default:   ms = 14'd250;
    endcase
    return ms;
  endfunction

  function automatic logic [3:0] digits(input logic [1:0] rng);
    logic [3:0] d;
    case (rng)
      RANGE_ONE: d = 4'd9;
      RANGE_TEN: d = 4'd10;
      default:   d = 4'd8;
    endcase
    return d;
  endfunction

endpackage

@@ src/reciprocal_frequency_counter_unit.sv @@
// reciprocal_frequency_counter_unit: top level of the reciprocal frequency counter.
// Depends on rfc_pkg (constants, state type, gate and digit tables).
//
// Each input word is either a gate edge (counts for bank A or B) or a range
// button press. A gate edge with nonzero deltas and a positive scaled reference
// runs one shared shift-add multiplier ((10*ref + offset) * sig_delta * 100)
// and then a restoring divider by ref_delta, one quotient bit per cycle,
// passing through ST_MUL, ST_DIV and ST_FIN to ST_OUT, where its result word
// is presented. Range presses and edges that need no division show their
// result in the cycle after acceptance. A result word that waits holds off
// the next word. The block holds one word at a time: s_axis_tready is low
// from acceptance until the result word has been taken. Configuration
// writes to ref_freq_hz take effect at once and belong in idle periods only.

module reciprocal_frequency_counter_unit #(
  parameter int COUNT_BITS = rfc_pkg::COUNT_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rfc_pkg::REF_W-1:0]          cfg_wdata,     // ref_freq_hz
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [31:0] ref_count, [63:32] sig_count, [64] cal_button, rest zero
  input  logic [rfc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [0] action, [1] gate_level
  input  logic [rfc_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [39:0] freq_millihertz, [41:40] unit_code, [43:42] range_code,
  // [57:44] gate_time_ms, [61:58] display_digits, [62] calibrating,
  // [63] cal_done, [79:64] correction_offset, [80] restart_gate, rest zero
  output logic [rfc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // [0] measure_valid
  output logic [rfc_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);

  localparam int A_W   = rfc_pkg::SCALED_W;
  localparam int B_W   = COUNT_BITS + 7;          // sig_delta * 100
  localparam int P_W   = A_W + B_W;               // full product width
  localparam int R_W   = COUNT_BITS + 1;          // shifted partial remainder
  localparam int CNT_W = $clog2(P_W + 1);
  localparam int SOFF_W = ((COUNT_BITS > A_W) ? COUNT_BITS : A_W) + 2;
  localparam int FW    = rfc_pkg::FREQ_W;

  rfc_pkg::state_t state;

  // configuration and persistent state
  logic [rfc_pkg::REF_W-1:0]    ref_freq_hz;
  logic [COUNT_BITS-1:0]        last_ref_a, last_sig_a, last_ref_b, last_sig_b;
  logic signed [rfc_pkg::OFF_W-1:0] offset_reg;
  logic [1:0]                   range_reg, saved_range, cal_left;
  logic                         cal_active;

  // datapath of the shared multiply / divide engine
  logic [P_W-1:0]        acc;
  logic [A_W-1:0]        a_reg;
  logic [B_W-1:0]        b_reg;
  logic [COUNT_BITS-1:0] rd_reg;
  logic [COUNT_BITS-1:0] rem;
  logic [FW-1:0]         quo;
  logic                  quo_ovf;
  logic [CNT_W-1:0]      cnt;

  // result registers
  logic          o_valid, o_done, o_restart;
  logic [FW-1:0] o_freq;
  logic [1:0]    o_unit;

  // decode of the incoming word
  logic                  in_acc;
  logic                  in_action, in_level, in_cal;
  logic [COUNT_BITS-1:0] rc, sc, rd, sd;
  logic [A_W-1:0]        ten_ref;
  logic signed [A_W+1:0] scaled;
  logic                  scaled_pos, need_calc;
  logic [B_W-1:0]        b_val;
  logic signed [SOFF_W-1:0] off_wide;
  logic signed [rfc_pkg::OFF_W-1:0] off_sat;

  // cal sequencing next values
  logic [1:0] cal_left_next, range_next, saved_range_next;
  logic       cal_active_next, done_next;

  // divider step
  logic [R_W-1:0] r_shift;
  logic           r_ge;
  logic [R_W-1:0] r_sub;

  // final compare
  logic above_mhz, above_khz;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign in_action = s_axis_tuser[0];
  assign in_level  = s_axis_tuser[1];
  assign in_cal    = s_axis_tdata[2*rfc_pkg::IN_CNT_W];
  assign rc = COUNT_BITS'(s_axis_tdata[rfc_pkg::IN_CNT_W-1:0]);
  assign sc = COUNT_BITS'(s_axis_tdata[2*rfc_pkg::IN_CNT_W-1:rfc_pkg::IN_CNT_W]);

  always_comb begin
    if (in_level) begin
      rd = rc - last_ref_b;
      sd = sc - last_sig_b;
    end else begin
      rd = rc - last_ref_a;
      sd = sc - last_sig_a;
    end
  end

  assign ten_ref = (A_W'(ref_freq_hz) << 3) + (A_W'(ref_freq_hz) << 1);
  assign scaled  = $signed({2'b00, ten_ref}) +
                   $signed({{(A_W+2-rfc_pkg::OFF_W){offset_reg[rfc_pkg::OFF_W-1]}},
                            offset_reg});
  assign scaled_pos = !scaled[A_W+1] && (scaled != '0);
  assign need_calc  = scaled_pos && (rd != '0) && (sd != '0);
  assign b_val = (B_W'(sd) << 6) + (B_W'(sd) << 5) + (B_W'(sd) << 2);

  // calibration offset, computed from the measured reference delta
  assign off_wide = $signed(SOFF_W'(rd)) - $signed(SOFF_W'(ten_ref));
  always_comb begin
    if (off_wide > $signed(SOFF_W'(rfc_pkg::OFF_MAX)))
      off_sat = rfc_pkg::OFF_W'(rfc_pkg::OFF_MAX);
    else if (off_wide < $signed(SOFF_W'(rfc_pkg::OFF_MIN)))
      off_sat = rfc_pkg::OFF_W'(rfc_pkg::OFF_MIN);
    else
      off_sat = off_wide[rfc_pkg::OFF_W-1:0];
  end

  always_comb begin
    cal_left_next    = (cal_active && cal_left != 2'd0) ? cal_left - 2'd1 : cal_left;
    cal_active_next  = cal_active;
    saved_range_next = saved_range;
    range_next       = range_reg;
    done_next        = 1'b0;
    if (in_cal) begin
      cal_left_next    = rfc_pkg::CAL_EDGES;
      cal_active_next  = 1'b1;
      saved_range_next = range_reg;
      range_next       = rfc_pkg::RANGE_TEN;
    end
    if (cal_active_next && cal_left_next == 2'd0) begin
      cal_active_next = 1'b0;
      cal_left_next   = rfc_pkg::CAL_EDGES;
      range_next      = (saved_range_next == rfc_pkg::RANGE_ONE ||
                         saved_range_next == rfc_pkg::RANGE_TEN) ?
                        saved_range_next : rfc_pkg::RANGE_QUARTER;
      done_next       = 1'b1;
    end
  end

  // one restoring divide step
  assign r_shift = {rem, acc[P_W-1]};
  assign r_ge    = r_shift >= {1'b0, rd_reg};
  assign r_sub   = r_shift - {1'b0, rd_reg};

  assign above_mhz = quo_ovf || quo > rfc_pkg::MHZ_LIMIT ||
                     (quo == rfc_pkg::MHZ_LIMIT && rem != '0);
  assign above_khz = quo_ovf || quo > rfc_pkg::KHZ_LIMIT ||
                     (quo == rfc_pkg::KHZ_LIMIT && rem != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rfc_pkg::ST_IDLE;
      ref_freq_hz <= rfc_pkg::REF_RESET;
      last_ref_a  <= '0;
      last_sig_a  <= '0;
      last_ref_b  <= '0;
      last_sig_b  <= '0;
      offset_reg  <= '0;
      range_reg   <= rfc_pkg::RANGE_ONE;
      saved_range <= rfc_pkg::RANGE_ONE;
      cal_active  <= 1'b0;
      cal_left    <= rfc_pkg::CAL_EDGES;
    end else begin
      if (cfg_we) begin
        ref_freq_hz <= cfg_wdata;
      end
      case (state)
        rfc_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (in_action == rfc_pkg::ACT_RANGE) begin
              range_reg <= (range_reg == rfc_pkg::RANGE_QUARTER) ? rfc_pkg::RANGE_ONE :
                           (range_reg == rfc_pkg::RANGE_ONE)     ? rfc_pkg::RANGE_TEN :
                                                                   rfc_pkg::RANGE_QUARTER;
              state <= rfc_pkg::ST_OUT;
            end else begin
              if (in_level) begin
                last_ref_b <= rc;
                last_sig_b <= sc;
              end else begin
                last_ref_a <= rc;
                last_sig_a <= sc;
              end
              cal_left    <= cal_left_next;
              cal_active  <= cal_active_next;
              saved_range <= saved_range_next;
              range_reg   <= range_next;
              if (done_next) begin
                offset_reg <= off_sat;
              end
              state <= need_calc ? rfc_pkg::ST_MUL : rfc_pkg::ST_OUT;
            end
          end
        end
        rfc_pkg::ST_MUL: begin
          if (cnt == CNT_W'(1)) begin
            state <= rfc_pkg::ST_DIV;
          end
        end
        rfc_pkg::ST_DIV: begin
          if (cnt == CNT_W'(1)) begin
            state <= rfc_pkg::ST_FIN;
          end
        end
        rfc_pkg::ST_FIN: begin
          state <= rfc_pkg::ST_OUT;
        end
        rfc_pkg::ST_OUT: begin
          if (m_axis_tready) begin
            state <= rfc_pkg::ST_IDLE;
          end
        end
        default: state <= rfc_pkg::ST_IDLE;
      endcase
    end
  end

  // engine and result registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      rfc_pkg::ST_IDLE: begin
        if (in_acc) begin
          acc       <= '0;
          a_reg     <= scaled[A_W-1:0];
          b_reg     <= b_val;
          rd_reg    <= rd;
          rem       <= '0;
          quo       <= '0;
          quo_ovf   <= 1'b0;
          cnt       <= CNT_W'(A_W);
          o_freq    <= '0;
          o_unit    <= rfc_pkg::UNIT_HZ;
          o_valid   <= (in_action == rfc_pkg::ACT_GATE) && (rd != '0);
          o_done    <= (in_action == rfc_pkg::ACT_GATE) && done_next;
          o_restart <= (in_action == rfc_pkg::ACT_RANGE) || done_next;
        end
      end
      rfc_pkg::ST_MUL: begin
        // shift-add over the scaled reference, msb first
        acc   <= {acc[P_W-2:0], 1'b0} + (a_reg[A_W-1] ? P_W'(b_reg) : '0);
        a_reg <= {a_reg[A_W-2:0], 1'b0};
        cnt   <= (cnt == CNT_W'(1)) ? CNT_W'(P_W) : cnt - CNT_W'(1);
      end
      rfc_pkg::ST_DIV: begin
        acc     <= {acc[P_W-2:0], 1'b0};
        rem     <= r_ge ? r_sub[COUNT_BITS-1:0] : r_shift[COUNT_BITS-1:0];
        quo     <= {quo[FW-2:0], r_ge};
        quo_ovf <= quo_ovf | quo[FW-1];
        cnt     <= cnt - CNT_W'(1);
      end
      rfc_pkg::ST_FIN: begin
        o_freq <= quo_ovf ? '1 : quo;
        o_unit <= above_mhz ? rfc_pkg::UNIT_MHZ :
                  above_khz ? rfc_pkg::UNIT_KHZ : rfc_pkg::UNIT_HZ;
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state == rfc_pkg::ST_IDLE);
  assign m_axis_tvalid = (state == rfc_pkg::ST_OUT);
  assign m_axis_tuser  = o_valid;
  assign m_axis_tdata  = {7'd0, o_restart, offset_reg, o_done, cal_active,
                          rfc_pkg::digits(range_reg), rfc_pkg::gate_ms(range_reg),
                          range_reg, o_unit, o_freq};

endmodule

@@ src/rfc_chk.sv @@
// rfc_chk: port-level checker for the reciprocal frequency counter, bound
// to the top level. Depends on rfc_pkg for the port widths.

module rfc_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [rfc_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

  // one word in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a word is in flight");

  // no new input while a result word is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while result pending");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // invalid measurement carries zero frequency and hz unit
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tdata[39:0] == '0 && m_axis_tdata[41:40] == rfc_pkg::UNIT_HZ)
    else $error("invalid word with nonzero frequency");

  // range code never shows the unused code
  a_range_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[43:42] != 2'd3)
    else $error("range code out of table");

endmodule

bind reciprocal_frequency_counter_unit rfc_chk u_rfc_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
